>>> src/six_vertex_clique_or_independent_search_core_assert.svh
// Assertion macros for the six-vertex clique / independent-set search core.
// Included by the top level; depends on nothing else.
`ifndef SIX_VERTEX_CLIQUE_OR_INDEPENDENT_SEARCH_CORE_ASSERT_SVH
`define SIX_VERTEX_CLIQUE_OR_INDEPENDENT_SEARCH_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SVCIS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svcis same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define SVCIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svcis next-cycle check failed");
`else
`define SVCIS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SVCIS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/svcis_pkg.sv
// Package for the six-vertex clique / independent-set search core.
// Holds item structs, opcodes, status codes and sequencer states; no dependencies.
`default_nettype none

package svcis_pkg;

    // Width of a reported vertex index and size of the searched set.
    localparam int VERTEX_W   = 5;
    localparam int SET_SIZE   = 6;
    localparam int DEPTH_W    = 3;
    localparam logic [DEPTH_W-1:0] FIRST_DEPTH = '0;
    localparam logic [DEPTH_W-1:0] LAST_DEPTH  = DEPTH_W'(SET_SIZE - 1);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_SEARCH = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_DUP     = 2'd2
    } edge_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE_CHECK,
        S_EDGE_WRB,
        S_PICK,
        S_LOAD,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
        logic                want_edges;
    } item_t;

    typedef struct packed {
        logic [1:0]          edge_status;
        logic                found;
        logic [VERTEX_W-1:0] witness_0;
        logic [VERTEX_W-1:0] witness_1;
        logic [VERTEX_W-1:0] witness_2;
        logic [VERTEX_W-1:0] witness_3;
        logic [VERTEX_W-1:0] witness_4;
        logic [VERTEX_W-1:0] witness_5;
    } result_t;

    // Control from the sequencer to the adjacency store.
    typedef struct packed {
        logic clear;
        logic wr_en;
    } mem_ctl_t;

endpackage

`default_nettype wire

>>> src/svcis_adj_mem.sv
// Adjacency row store: one row of neighbor bits per vertex, one write and one
// registered read per cycle, with per-row valid bits for clearing without a sweep. Uses svcis_pkg.
`default_nettype none

module svcis_adj_mem #(
    parameter int NUM_VERTICES = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire svcis_pkg::mem_ctl_t             ctl,
    input  wire logic [$clog2(NUM_VERTICES)-1:0] wr_addr,
    input  wire logic [NUM_VERTICES-1:0]         wr_data,
    input  wire logic [$clog2(NUM_VERTICES)-1:0] rd_addr,
    output logic      [NUM_VERTICES-1:0]         rd_data
);

    logic [NUM_VERTICES-1:0] mem [NUM_VERTICES];
    logic [NUM_VERTICES-1:0] valid_reg;
    logic [NUM_VERTICES-1:0] rd_data_reg;

    // A row reads as empty until it has been written since the last clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.clear)
        begin
            valid_reg <= '0;
        end
        else if (ctl.wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Row storage and registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/six_vertex_clique_or_independent_search_core.sv
// Top level of the six-vertex clique / independent-set search core.
// Uses svcis_pkg, svcis_adj_mem and the assertion macro header.
`default_nettype none
`include "six_vertex_clique_or_independent_search_core_assert.svh"

// Holds an undirected graph of NUM_VERTICES vertices and answers one item at a
// time, with exactly one result transfer per item. A clear or an unused opcode
// goes from acceptance straight to S_FINISH, where the result register is
// loaded; an edge add goes there at once when rejected for order or range, and
// otherwise through S_EDGE_CHECK, then S_EDGE_WRB when the edge is new. A search
// is a depth-first walk in ascending vertex order: each of the first five chosen
// vertices takes S_PICK, then one adjacency row read through the store's single
// registered read port in S_LOAD, the sixth takes S_PICK alone, and each
// exhausted level backs out in S_PICK, before S_FINISH loads the result. The
// search time depends on the graph. The item channel stalls until the result
// register is loaded; the result register frees it to take the next item while
// an earlier result still waits. Clearing is done by per-row valid bits and
// needs no sweep after reset.
module six_vertex_clique_or_independent_search_core #(
    parameter int NUM_VERTICES = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire svcis_pkg::item_t  item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output svcis_pkg::result_t     result
);

    localparam int IDXW = $clog2(NUM_VERTICES);
    localparam logic [NUM_VERTICES-1:0] ROW_ONE  = NUM_VERTICES'(1);
    localparam logic [NUM_VERTICES-1:0] ALL_ROWS = '1;

    typedef logic [IDXW-1:0]         vidx_t;
    typedef logic [NUM_VERTICES-1:0] row_t;

    svcis_pkg::state_t  state_reg, state_next;
    svcis_pkg::item_t   item_reg, item_next;
    logic [svcis_pkg::DEPTH_W-1:0] depth_reg, depth_next;
    row_t               cand_reg [svcis_pkg::SET_SIZE];
    row_t               cand_next [svcis_pkg::SET_SIZE];
    vidx_t              wit_reg [svcis_pkg::SET_SIZE];
    vidx_t              wit_next [svcis_pkg::SET_SIZE];
    logic               found_reg, found_next;
    logic [1:0]         status_reg, status_next;
    svcis_pkg::result_t result_reg, result_next;
    logic               result_valid_reg, result_valid_next;

    svcis_pkg::mem_ctl_t mem_ctl;
    vidx_t              wr_addr;
    row_t               wr_data;
    vidx_t              rd_addr;
    row_t               row_q;

    row_t               cur_cand;
    row_t               low_onehot;
    vidx_t              low_idx;
    row_t               compat;
    vidx_t              a_idx;
    vidx_t              b_idx;
    logic               bad_edge;

    logic               item_xfer;
    logic               finish_found;
    logic               wit_ascending;
    logic               found_with_status;

    svcis_adj_mem #(
        .NUM_VERTICES(NUM_VERTICES)
    ) u_adj_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (row_q)
    );

    // Lowest remaining candidate at the current depth.
    always_comb
    begin
        cur_cand   = cand_reg[depth_reg];
        low_onehot = cur_cand & (~cur_cand + ROW_ONE);
        low_idx    = '0;
        for (int i = 0; i < NUM_VERTICES; i++)
        begin
            if (low_onehot[i])
            begin
                low_idx = low_idx | IDXW'(i);
            end
        end
    end

    // Vertices that may join a set holding the vertex whose row was just read.
    assign compat = item_reg.want_edges ? row_q : (~row_q & ALL_ROWS);

    // Edge endpoints as store indices; the range check uses the full field.
    assign a_idx    = IDXW'(item_reg.vertex_a);
    assign b_idx    = IDXW'(item_reg.vertex_b);
    assign bad_edge = (item.vertex_a >= item.vertex_b) ||
                      (32'(item.vertex_b) >= 32'(NUM_VERTICES));

    assign item_stall = (state_reg != svcis_pkg::S_IDLE);

    // Sequencer: next state, search stack updates and store control.
    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        depth_next        = depth_reg;
        cand_next         = cand_reg;
        wit_next          = wit_reg;
        found_next        = found_reg;
        status_next       = status_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        mem_ctl           = '0;
        wr_addr           = a_idx;
        wr_data           = row_q;
        rd_addr           = low_idx;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            svcis_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next   = item;
                    found_next  = 1'b0;
                    status_next = svcis_pkg::ST_OK;
                    depth_next  = svcis_pkg::FIRST_DEPTH;
                    state_next  = svcis_pkg::S_FINISH;
                    case (item.opcode)
                        svcis_pkg::OP_CLEAR:
                        begin
                            mem_ctl.clear = 1'b1;
                        end
                        svcis_pkg::OP_ADD:
                        begin
                            if (bad_edge)
                            begin
                                status_next = svcis_pkg::ST_INVALID;
                            end
                            else
                            begin
                                rd_addr    = IDXW'(item.vertex_a);
                                state_next = svcis_pkg::S_EDGE_CHECK;
                            end
                        end
                        svcis_pkg::OP_SEARCH:
                        begin
                            cand_next[0] = ALL_ROWS;
                            state_next   = svcis_pkg::S_PICK;
                        end
                        default:
                        begin
                            state_next = svcis_pkg::S_FINISH;
                        end
                    endcase
                end
            end

            svcis_pkg::S_EDGE_CHECK:
            begin
                if (row_q[b_idx])
                begin
                    status_next = svcis_pkg::ST_DUP;
                    state_next  = svcis_pkg::S_FINISH;
                end
                else
                begin
                    mem_ctl.wr_en = 1'b1;
                    wr_addr       = a_idx;
                    wr_data       = row_q | (ROW_ONE << b_idx);
                    rd_addr       = b_idx;
                    state_next    = svcis_pkg::S_EDGE_WRB;
                end
            end

            svcis_pkg::S_EDGE_WRB:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = b_idx;
                wr_data       = row_q | (ROW_ONE << a_idx);
                state_next    = svcis_pkg::S_FINISH;
            end

            svcis_pkg::S_PICK:
            begin
                if (cur_cand == '0)
                begin
                    // Level exhausted: back out, or give up at the root.
                    if (depth_reg == svcis_pkg::FIRST_DEPTH)
                    begin
                        found_next = 1'b0;
                        state_next = svcis_pkg::S_FINISH;
                    end
                    else
                    begin
                        depth_next = depth_reg - 3'd1;
                    end
                end
                else
                begin
                    wit_next[depth_reg]  = low_idx;
                    cand_next[depth_reg] = cur_cand & ~low_onehot;
                    if (depth_reg == svcis_pkg::LAST_DEPTH)
                    begin
                        found_next = 1'b1;
                        state_next = svcis_pkg::S_FINISH;
                    end
                    else
                    begin
                        rd_addr    = low_idx;
                        state_next = svcis_pkg::S_LOAD;
                    end
                end
            end

            svcis_pkg::S_LOAD:
            begin
                // Remaining higher candidates filtered by the chosen vertex's row.
                cand_next[depth_reg + 3'd1] = cur_cand & compat;
                depth_next                  = depth_reg + 3'd1;
                state_next                  = svcis_pkg::S_PICK;
            end

            svcis_pkg::S_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.edge_status = status_reg;
                    result_next.found       = found_reg;
                    result_next.witness_0   = found_reg ? svcis_pkg::VERTEX_W'(wit_reg[0]) : '0;
                    result_next.witness_1   = found_reg ? svcis_pkg::VERTEX_W'(wit_reg[1]) : '0;
                    result_next.witness_2   = found_reg ? svcis_pkg::VERTEX_W'(wit_reg[2]) : '0;
                    result_next.witness_3   = found_reg ? svcis_pkg::VERTEX_W'(wit_reg[3]) : '0;
                    result_next.witness_4   = found_reg ? svcis_pkg::VERTEX_W'(wit_reg[4]) : '0;
                    result_next.witness_5   = found_reg ? svcis_pkg::VERTEX_W'(wit_reg[5]) : '0;
                    result_valid_next       = 1'b1;
                    state_next              = svcis_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = svcis_pkg::S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= svcis_pkg::S_IDLE;
            depth_reg        <= svcis_pkg::FIRST_DEPTH;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            depth_reg        <= depth_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload and search stack.
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        cand_reg   <= cand_next;
        wit_reg    <= wit_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Terms used by the checks below.
    assign item_xfer         = item_valid && !item_stall;
    assign finish_found      = (state_reg == svcis_pkg::S_FINISH) && found_reg;
    assign wit_ascending     = (wit_reg[0] < wit_reg[1]) && (wit_reg[1] < wit_reg[2]) &&
                               (wit_reg[2] < wit_reg[3]) && (wit_reg[3] < wit_reg[4]) &&
                               (wit_reg[4] < wit_reg[5]);
    assign found_with_status = result.found && (result.edge_status != svcis_pkg::ST_OK);

    // Checks on the sequencer and the search stack.
    `SVCIS_ASSERT_IMP(a_depth_range, clk, rst_n, 1'b1, depth_reg <= svcis_pkg::LAST_DEPTH)
    `SVCIS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, item_xfer, state_reg != svcis_pkg::S_IDLE)
    `SVCIS_ASSERT_IMP(a_witness_ascending, clk, rst_n, finish_found, wit_ascending)
    `SVCIS_ASSERT_IMP(a_status_or_found, clk, rst_n, result_valid, !found_with_status)

endmodule

`default_nettype wire

>>> bench/tb_six_vertex_clique_or_independent_search_core.sv
// Self-checking testbench for the six-vertex clique / independent-set search core.
// Depends on svcis_pkg and the core RTL; predicts every result from its own graph copy.
`default_nettype none

module tb_six_vertex_clique_or_independent_search_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV           = 32;
    localparam int GROUPS       = 5;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    // Opcode value that the core does not define.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    svcis_pkg::item_t   item         = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    svcis_pkg::result_t result;

    // Graph copy used for prediction, and results still owed by the core.
    logic [NV-1:0]      adj_rows [NV];
    svcis_pkg::result_t pending_results [$];

    int fail_count   = 0;
    int report_count = 0;
    bit quiet        = 1'b0;
    bit hold_request = 1'b0;

    six_vertex_clique_or_independent_search_core #(
        .NUM_VERTICES (NV)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Depth-first search in ascending vertex order; the first hit is the
    // lexicographically smallest homogeneous six-set.
    function automatic svcis_pkg::result_t search_six_set(logic want);
        logic [NV-1:0]      cand [svcis_pkg::SET_SIZE+1];
        int                 chosen [svcis_pkg::SET_SIZE];
        int                 start_at [svcis_pkg::SET_SIZE+1];
        int                 depth;
        int                 u;
        logic               done;
        svcis_pkg::result_t r;
        r           = '0;
        cand[0]     = '1;
        depth       = 0;
        start_at[0] = 0;
        done        = 1'b0;
        while (!done)
        begin
            if (depth == svcis_pkg::SET_SIZE)
            begin
                r.found     = 1'b1;
                r.witness_0 = svcis_pkg::VERTEX_W'(chosen[0]);
                r.witness_1 = svcis_pkg::VERTEX_W'(chosen[1]);
                r.witness_2 = svcis_pkg::VERTEX_W'(chosen[2]);
                r.witness_3 = svcis_pkg::VERTEX_W'(chosen[3]);
                r.witness_4 = svcis_pkg::VERTEX_W'(chosen[4]);
                r.witness_5 = svcis_pkg::VERTEX_W'(chosen[5]);
                done        = 1'b1;
            end
            else
            begin
                u = start_at[depth];
                while (u < NV && !cand[depth][u])
                    u++;
                if (u >= NV)
                begin
                    // This level is exhausted: back out to the previous choice.
                    if (depth == 0)
                        done = 1'b1;
                    else
                    begin
                        depth--;
                        start_at[depth] = chosen[depth] + 1;
                    end
                end
                else
                begin
                    chosen[depth]   = u;
                    cand[depth + 1] = cand[depth] & (want ? adj_rows[u] : ~adj_rows[u])
                                      & ({NV{1'b1}} << (u + 1));
                    depth++;
                    start_at[depth] = 0;
                end
            end
        end
        return r;
    endfunction

    // Applies one item to the graph copy and returns the result it causes.
    function automatic svcis_pkg::result_t apply_graph_item(svcis_pkg::item_t it);
        svcis_pkg::result_t r;
        int                 a;
        int                 b;
        r = '0;
        a = it.vertex_a;
        b = it.vertex_b;
        case (it.opcode)
            svcis_pkg::OP_CLEAR:
            begin
                for (int k = 0; k < NV; k++)
                    adj_rows[k] = '0;
            end
            svcis_pkg::OP_ADD:
            begin
                if (a >= b || b >= NV)
                    r.edge_status = svcis_pkg::ST_INVALID;
                else if (adj_rows[a][b])
                    r.edge_status = svcis_pkg::ST_DUP;
                else
                begin
                    adj_rows[a][b] = 1'b1;
                    adj_rows[b][a] = 1'b1;
                end
            end
            svcis_pkg::OP_SEARCH:
                r = search_six_set(it.want_edges);
            default:
                r = '0;
        endcase
        return r;
    endfunction

    function automatic svcis_pkg::item_t make_item(logic [1:0] op, int a, int b, logic want);
        svcis_pkg::item_t it;
        it.opcode     = op;
        it.vertex_a   = svcis_pkg::VERTEX_W'(a);
        it.vertex_b   = svcis_pkg::VERTEX_W'(b);
        it.want_edges = want;
        return it;
    endfunction

    function automatic string describe(svcis_pkg::result_t r);
        return $sformatf("status=%0d found=%0d witness=%0d,%0d,%0d,%0d,%0d,%0d",
                         r.edge_status, r.found, r.witness_0, r.witness_1,
                         r.witness_2, r.witness_3, r.witness_4, r.witness_5);
    endfunction

    // Offers one item, optionally after a short idle burst, and waits for its transfer.
    task automatic send_item(svcis_pkg::item_t it);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        pending_results.push_back(apply_graph_item(it));
    endtask

    task automatic shuffle_list(ref int q[$]);
        int j;
        int tmp;
        for (int k = q.size() - 1; k > 0; k--)
        begin
            j    = $urandom_range(0, k);
            tmp  = q[k];
            q[k] = q[j];
            q[j] = tmp;
        end
    endtask

    // Sends each edge of the list, now and then reversed or repeated.
    task automatic send_edge_list(int pairs[$]);
        int a;
        int b;
        foreach (pairs[k])
        begin
            a = pairs[k] / NV;
            b = pairs[k] % NV;
            if ($urandom_range(0, 15) == 0)
                send_item(make_item(svcis_pkg::OP_ADD, b, a, 1'($urandom)));
            send_item(make_item(svcis_pkg::OP_ADD, a, b, 1'($urandom)));
            if ($urandom_range(0, 15) == 0)
                send_item(make_item(svcis_pkg::OP_ADD, a, b, 1'($urandom)));
        end
    endtask

    // Status codes of edge adds, including reversed order and repeats.
    task automatic test_edge_status();
        send_item(make_item(svcis_pkg::OP_CLEAR, 31, 31, 1'b1));
        send_item(make_item(svcis_pkg::OP_ADD, 0, 31, 1'b0));
        send_item(make_item(svcis_pkg::OP_ADD, 0, 31, 1'b1));
        send_item(make_item(svcis_pkg::OP_ADD, 7, 7, 1'b0));
        send_item(make_item(svcis_pkg::OP_ADD, 31, 0, 1'b1));
        send_item(make_item(svcis_pkg::OP_ADD, 30, 31, 1'b0));
        send_item(make_item(svcis_pkg::OP_ADD, 31, 30, 1'b0));
    endtask

    // Searches on a nearly empty graph: clique miss and independent hits.
    task automatic test_empty_searches();
        send_item(make_item(svcis_pkg::OP_SEARCH, 31, 0, 1'b1));
        send_item(make_item(svcis_pkg::OP_SEARCH, 0, 31, 1'b0));
        send_item(make_item(svcis_pkg::OP_ADD, 0, 1, 1'b0));
        send_item(make_item(svcis_pkg::OP_ADD, 0, 2, 1'b0));
        send_item(make_item(svcis_pkg::OP_SEARCH, 31, 31, 1'b0));
        send_item(make_item(svcis_pkg::OP_CLEAR, 0, 0, 1'b0));
        send_item(make_item(svcis_pkg::OP_SEARCH, 31, 31, 1'b0));
        send_item(make_item(svcis_pkg::OP_SEARCH, 0, 0, 1'b1));
    endtask

    // The unused opcode returns an all-zero result whatever its other fields hold.
    task automatic test_unused_opcode();
        send_item(make_item(OP_UNUSED, 31, 31, 1'b1));
        send_item(make_item(OP_UNUSED, 0, 0, 1'b0));
        send_item(make_item(svcis_pkg::OP_SEARCH, 0, 0, 1'b1));
    endtask

    // Plants a six-clique among random noise edges, then searches in both modes.
    task automatic test_planted_clique();
        int            members [svcis_pkg::SET_SIZE];
        int            pairs [$];
        logic [NV-1:0] used;
        int            n;
        used = '0;
        for (int k = 0; k < svcis_pkg::SET_SIZE; k++)
        begin
            do
                n = $urandom_range(0, NV - 1);
            while (used[n]);
            used[n]    = 1'b1;
            members[k] = n;
        end
        send_item(make_item(svcis_pkg::OP_CLEAR, $urandom, $urandom, 1'($urandom)));
        repeat ($urandom_range(0, 8))
            send_item(make_item(svcis_pkg::OP_ADD, $urandom, $urandom, 1'($urandom)));
        for (int k = 0; k < svcis_pkg::SET_SIZE; k++)
            for (int j = k + 1; j < svcis_pkg::SET_SIZE; j++)
                if (members[k] < members[j])
                    pairs.push_back(members[k] * NV + members[j]);
                else
                    pairs.push_back(members[j] * NV + members[k]);
        shuffle_list(pairs);
        send_edge_list(pairs);
        send_item(make_item(svcis_pkg::OP_SEARCH, $urandom, $urandom, 1'b1));
        send_item(make_item(svcis_pkg::OP_SEARCH, $urandom, $urandom, 1'b0));
    endtask

    // Covers all vertices with five disjoint cliques, so no independent six-set exists.
    task automatic test_partition_cover();
        int order [$];
        int pairs [$];
        int a;
        int b;
        for (int k = 0; k < NV; k++)
            order.push_back(k);
        shuffle_list(order);
        for (int k = 0; k < NV; k++)
            for (int j = k + 1; j < NV; j++)
                if (k % GROUPS == j % GROUPS)
                begin
                    a = (order[k] < order[j]) ? order[k] : order[j];
                    b = (order[k] < order[j]) ? order[j] : order[k];
                    pairs.push_back(a * NV + b);
                end
        shuffle_list(pairs);
        send_item(make_item(svcis_pkg::OP_CLEAR, $urandom, $urandom, 1'($urandom)));
        send_edge_list(pairs);
        send_item(make_item(svcis_pkg::OP_SEARCH, $urandom, $urandom, 1'b0));
        send_item(make_item(svcis_pkg::OP_SEARCH, $urandom, $urandom, 1'b1));
    endtask

    // Fully random items, starting from an empty graph.
    task automatic test_random_items();
        send_item(make_item(svcis_pkg::OP_CLEAR, $urandom, $urandom, 1'($urandom)));
        repeat (8)
            send_item(svcis_pkg::item_t'($urandom_range(0, (1 << $bits(svcis_pkg::item_t)) - 1)));
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_result_backpressure();
        hold_request = 1'b1;
        repeat (8)
            send_item(make_item(svcis_pkg::OP_ADD, $urandom, $urandom, 1'($urandom)));
    endtask

    // Last part without any idling on either side.
    task automatic test_quiet_finish();
        quiet = 1'b1;
        test_planted_clique();
    endtask

    // Result receiver: random stall bursts, plus one long hold on request.
    initial
    begin
        int burst;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 5);
                result_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Compares every result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        svcis_pkg::result_t want;
        logic               bad;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (report_count < MAX_REPORTS)
                    $display("unexpected result: %s", describe(result));
                report_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                bad  = (result.edge_status !== want.edge_status)
                    || (result.found !== want.found)
                    || (result.witness_0 !== want.witness_0)
                    || (result.witness_1 !== want.witness_1)
                    || (result.witness_2 !== want.witness_2)
                    || (result.witness_3 !== want.witness_3)
                    || (result.witness_4 !== want.witness_4)
                    || (result.witness_5 !== want.witness_5);
                if (bad)
                begin
                    fail_count++;
                    if (report_count < MAX_REPORTS)
                        $display("mismatch: expected %s actual %s",
                                 describe(want), describe(result));
                    report_count++;
                end
            end
        end
    end

    // Run limit for a hung core.
    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Reset, then the tests in turn, then wait for the last results.
    initial
    begin
        for (int k = 0; k < NV; k++)
            adj_rows[k] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_status();
        test_empty_searches();
        test_unused_opcode();
        test_partition_cover();
        test_random_items();
        test_result_backpressure();
        test_quiet_finish();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
